// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(name, clk, rst_n, cond)
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/tsc_pkg.sv =====
package tsc_pkg;

	localparam int POS_W = 16;
	localparam int MAX_RES = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;
	localparam logic [15:0] LENGTH_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_NUMBER = 2'd1,
		MODE_IDENT  = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		KIND_NUMBER  = 4'd0,
		KIND_IDENT   = 4'd1,
		KIND_PLUS    = 4'd2,
		KIND_MINUS   = 4'd3,
		KIND_TIMES   = 4'd4,
		KIND_DIVIDE  = 4'd5,
		KIND_EQUALS  = 4'd6,
		KIND_NOT     = 4'd7,
		KIND_AND     = 4'd8,
		KIND_SEMI    = 4'd9,
		KIND_UNKNOWN = 4'd10,
		KIND_END     = 4'd11
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [30:0] value;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [1:0]               n;
		tok_t [MAX_RES-1:0]       tok;
	} tok_batch_t;

endpackage

// ===== design/tsc_lexer.sv =====
`include "assert_macros.svh"

module tsc_lexer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            text_byte,
	input  logic                  end_of_text,
	output tsc_pkg::tok_batch_t   batch
);

	tsc_pkg::mode_t                mode_q, mode_d;
	logic [30:0]                   value_q, value_d;
	logic [tsc_pkg::POS_W-1:0]     start_q, start_d;
	logic [15:0]                   len_q, len_d;
	logic [tsc_pkg::POS_W-1:0]     pos_q, pos_next;

	logic        is_digit, is_alpha, is_space;
	logic [3:0]  digit;
	logic [34:0] prod;
	logic [30:0] value_grown;
	logic [15:0] len_grown;
	tsc_pkg::mode_t mode_eff;

	function automatic tsc_pkg::kind_t symbol_kind(input logic [7:0] c);
		tsc_pkg::kind_t k;
		unique case (c)
			8'h2B:   k = tsc_pkg::KIND_PLUS;
			8'h2D:   k = tsc_pkg::KIND_MINUS;
			8'h2A:   k = tsc_pkg::KIND_TIMES;
			8'h2F:   k = tsc_pkg::KIND_DIVIDE;
			8'h3D:   k = tsc_pkg::KIND_EQUALS;
			8'h21:   k = tsc_pkg::KIND_NOT;
			8'h26:   k = tsc_pkg::KIND_AND;
			8'h3B:   k = tsc_pkg::KIND_SEMI;
			default: k = tsc_pkg::KIND_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic tsc_pkg::tok_t make_tok(input tsc_pkg::kind_t kind,
			input logic [30:0] value, input logic [tsc_pkg::POS_W-1:0] start,
			input logic [15:0] length);
		tsc_pkg::tok_t t;
		t.kind   = kind;
		t.value  = value;
		t.start  = 16'(start);
		t.length = length;
		t.last   = 1'b0;
		return t;
	endfunction

	assign is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
	assign is_alpha = ((text_byte >= 8'h41) && (text_byte <= 8'h5A)) ||
		((text_byte >= 8'h61) && (text_byte <= 8'h7A));
	assign is_space = (text_byte == 8'h20) || ((text_byte >= 8'h09) && (text_byte <= 8'h0D));
	assign digit    = text_byte[3:0];

	assign prod = ({4'b0, value_q} << 3) + ({4'b0, value_q} << 1) + 35'(digit);
	assign value_grown = (prod > 35'(tsc_pkg::VALUE_MAX)) ? tsc_pkg::VALUE_MAX : prod[30:0];
	assign len_grown = (len_q == tsc_pkg::LENGTH_MAX) ? len_q : len_q + 16'd1;
	assign pos_next = pos_q + tsc_pkg::POS_W'(1);

	always_comb begin
		unique case (mode_q)
			tsc_pkg::MODE_NUMBER: mode_eff = tsc_pkg::MODE_NUMBER;
			tsc_pkg::MODE_IDENT:  mode_eff = tsc_pkg::MODE_IDENT;
			default:              mode_eff = tsc_pkg::MODE_IDLE;
		endcase
	end

	// update pending token and collect up to three results in order
	always_comb begin
		logic [1:0] k;
		k = 2'd0;
		batch = '0;
		mode_d = mode_eff;
		value_d = value_q;
		start_d = start_q;
		len_d = len_q;
		if (is_digit && mode_eff == tsc_pkg::MODE_NUMBER) begin
			value_d = value_grown;
			len_d = len_grown;
		end else if ((is_digit || is_alpha) && mode_eff == tsc_pkg::MODE_IDENT) begin
			len_d = len_grown;
		end else begin
			if (mode_eff == tsc_pkg::MODE_NUMBER) begin
				batch.tok[k] = make_tok(tsc_pkg::KIND_NUMBER, value_q, start_q, len_q);
				k = k + 2'd1;
			end else if (mode_eff == tsc_pkg::MODE_IDENT) begin
				batch.tok[k] = make_tok(tsc_pkg::KIND_IDENT, '0, start_q, len_q);
				k = k + 2'd1;
			end
			mode_d = tsc_pkg::MODE_IDLE;
			value_d = '0;
			start_d = '0;
			len_d = '0;
			if (is_digit) begin
				mode_d = tsc_pkg::MODE_NUMBER;
				value_d = 31'(digit);
				start_d = pos_q;
				len_d = 16'd1;
			end else if (is_alpha) begin
				mode_d = tsc_pkg::MODE_IDENT;
				start_d = pos_q;
				len_d = 16'd1;
			end else if (!is_space) begin
				batch.tok[k] = make_tok(symbol_kind(text_byte), '0, pos_q, 16'd1);
				k = k + 2'd1;
			end
		end
		if (end_of_text) begin
			if (mode_d == tsc_pkg::MODE_NUMBER) begin
				batch.tok[k] = make_tok(tsc_pkg::KIND_NUMBER, value_d, start_d, len_d);
				k = k + 2'd1;
			end else if (mode_d == tsc_pkg::MODE_IDENT) begin
				batch.tok[k] = make_tok(tsc_pkg::KIND_IDENT, '0, start_d, len_d);
				k = k + 2'd1;
			end
			batch.tok[k] = make_tok(tsc_pkg::KIND_END, '0, pos_next, 16'd0);
			k = k + 2'd1;
		end
		if (k != 2'd0) begin
			batch.tok[k - 2'd1].last = 1'b1;
		end
		batch.n = k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= tsc_pkg::MODE_IDLE;
			value_q <= '0;
			start_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
		end else if (fire) begin
			if (end_of_text) begin
				mode_q  <= tsc_pkg::MODE_IDLE;
				value_q <= '0;
				start_q <= '0;
				len_q   <= '0;
				pos_q   <= '0;
			end else begin
				mode_q  <= mode_d;
				value_q <= value_d;
				start_q <= start_d;
				len_q   <= len_d;
				pos_q   <= pos_next;
			end
		end
	end

	`ASSERT_IMPLIES(a_end_emits, clk, arst_n, fire && end_of_text, batch.n != 2'd0)
	`ASSERT_IMPLIES(a_end_is_last, clk, arst_n, fire && end_of_text, batch.tok[batch.n - 2'd1].kind == tsc_pkg::KIND_END)
	`ASSERT_NEXT(a_restart, clk, arst_n, fire && end_of_text, pos_q == '0 && mode_q == tsc_pkg::MODE_IDLE)
	`ASSERT_ALWAYS(a_idle_len, clk, arst_n, mode_q != tsc_pkg::MODE_IDLE || len_q == '0)

endmodule

// ===== design/tsc_out_fifo.sv =====
`include "assert_macros.svh"

module tsc_out_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  tsc_pkg::tok_batch_t         batch,
	input  logic                        pop,
	output logic [tsc_pkg::CNT_W-1:0]   space,
	output logic                        out_valid,
	output tsc_pkg::tok_t               out_tok
);

	tsc_pkg::tok_t                  mem_q [tsc_pkg::FIFO_DEPTH];
	logic [tsc_pkg::PTR_W-1:0]      head_q, tail_q;
	logic [tsc_pkg::CNT_W-1:0]      count_q;
	logic [1:0]                     push_n;
	logic                           do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign push_n    = push ? batch.n : 2'd0;
	assign space     = tsc_pkg::CNT_W'(tsc_pkg::FIFO_DEPTH) - count_q + tsc_pkg::CNT_W'(do_pop);
	assign out_valid = (count_q != '0);
	assign out_tok   = mem_q[head_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < tsc_pkg::MAX_RES; i++) begin
			if (2'(i) < push_n) begin
				mem_q[tail_q + tsc_pkg::PTR_W'(i)] <= batch.tok[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + tsc_pkg::PTR_W'(push_n);
			head_q  <= head_q + tsc_pkg::PTR_W'(do_pop);
			count_q <= count_q + tsc_pkg::CNT_W'(push_n) - tsc_pkg::CNT_W'(do_pop);
		end
	end

	`ASSERT_ALWAYS(a_count_max, clk, arst_n, count_q <= tsc_pkg::CNT_W'(tsc_pkg::FIFO_DEPTH))
	`ASSERT_IMPLIES(a_no_overflow, clk, arst_n, push, tsc_pkg::CNT_W'(batch.n) <= space)
	`ASSERT_NEXT(a_pop_moves, clk, arst_n, do_pop && push_n == 2'd0, count_q == $past(count_q) - 1'b1)

endmodule

// ===== design/token_scanner.sv =====
// token_scanner: byte-stream lexer.
// Input channel text_*: one source byte per request (text_byte) with
// end_of_text marking the final byte of a text. Output channel token_*:
// one token per request; last_of_run flags the final token caused by a
// given byte. A byte yields zero to three tokens (pending flush, symbol,
// end token).
// Path: an accepted byte is held in the input register, then the lexer
// writes its tokens into a 4-entry output queue that feeds the output.
// Throughput: one byte per cycle while each byte makes at most one token
// and the receiver takes tokens; the tokens of a byte that makes more
// leave one at a time through the single output port of the queue.
// A held byte advances only when the queue has room for all of its
// tokens, so a stalled receiver backs up into text_ready without loss.
// Reset clears the scanner to idle at offset 0 and empties the queue.
// After an end_of_text byte the scanner restarts at offset 0.
module token_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        token_valid,
	input  logic        token_ready,
	output logic [3:0]  token_kind,
	output logic [30:0] number_value,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic        last_of_run
);

	logic                          valid_s1;
	logic [7:0]                    byte_s1;
	logic                          last_s1;
	logic                          fire_s1;
	logic [tsc_pkg::CNT_W-1:0]     space;
	tsc_pkg::tok_batch_t           batch;
	tsc_pkg::tok_t                 head_tok;

	assign fire_s1    = valid_s1 && (tsc_pkg::CNT_W'(batch.n) <= space);
	assign text_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_ready && text_valid) begin
			byte_s1 <= text_byte;
			last_s1 <= end_of_text;
		end
	end

	tsc_lexer u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire_s1),
		.text_byte   (byte_s1),
		.end_of_text (last_s1),
		.batch       (batch)
	);

	tsc_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire_s1),
		.batch     (batch),
		.pop       (token_ready),
		.space     (space),
		.out_valid (token_valid),
		.out_tok   (head_tok)
	);

	assign token_kind   = head_tok.kind;
	assign number_value = head_tok.value;
	assign token_start  = head_tok.start;
	assign token_length = head_tok.length;
	assign last_of_run  = head_tok.last;

endmodule

// ===== sim/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 340;
	localparam int IDENT_LEN = 9;

	logic        clk;
	logic        arst_n;
	logic        text_valid;
	logic        text_ready;
	logic [7:0]  text_byte;
	logic        end_of_text;
	logic        token_valid;
	logic        token_ready;
	logic [3:0]  token_kind;
	logic [30:0] number_value;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;

	token_scanner uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.token_valid  (token_valid),
		.token_ready  (token_ready),
		.token_kind   (token_kind),
		.number_value (number_value),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	typedef struct packed {
		logic [7:0]      ch;
		logic            eot;
		logic            typed;
		tsc_pkg::kind_t  kind;
		logic [15:0]     start;
		logic [15:0]     len;
	} step_t;

	// typed rows carry the token the byte must give; others go through the scanner model
	step_t plan [26] = '{
		'{"+",   1'b0, 1'b1, tsc_pkg::KIND_PLUS,    16'd0, 16'd1},
		'{8'h00, 1'b0, 1'b1, tsc_pkg::KIND_UNKNOWN, 16'd1, 16'd1},
		'{8'hFF, 1'b0, 1'b1, tsc_pkg::KIND_UNKNOWN, 16'd2, 16'd1},
		'{"-",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"*",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"/",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"=",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"!",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"&",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{";",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"a",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"7",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{8'h0D, 1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"9",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"9",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"9",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"9",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"9",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"9",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"9",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"9",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"9",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"9",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{"x",   1'b0, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{8'h0A, 1'b1, 1'b0, tsc_pkg::KIND_NUMBER,  16'd0, 16'd0},
		'{" ",   1'b1, 1'b1, tsc_pkg::KIND_END,     16'd1, 16'd0}
	};

	string symbols = "+-*/=!&;";

	tsc_pkg::mode_t            lx_mode = tsc_pkg::MODE_IDLE;
	logic [30:0]               lx_value = '0;
	logic [15:0]               lx_start = '0;
	logic [15:0]               lx_length = '0;
	logic [tsc_pkg::POS_W-1:0] lx_pos = '0;

	tsc_pkg::tok_t due_tokens [$];
	tsc_pkg::tok_t want;

	int faults = 0;
	int tokens_checked = 0;
	int bytes_sent = 0;
	int texts_ended = 0;
	int burst_left = 0;

	function automatic bit is_digit(input logic [7:0] ch);
		return ch >= "0" && ch <= "9";
	endfunction

	function automatic bit is_alpha(input logic [7:0] ch);
		return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
	endfunction

	function automatic bit is_space(input logic [7:0] ch);
		return ch == " " || (ch >= 8'd9 && ch <= 8'd13);
	endfunction

	function automatic logic [7:0] rand_letter();
		return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25));
	endfunction

	function automatic void emit(input tsc_pkg::kind_t k, input logic [30:0] v,
			input logic [15:0] s, input logic [15:0] l);
		tsc_pkg::tok_t t;
		t.kind = k;
		t.value = v;
		t.start = s;
		t.length = l;
		t.last = 1'b0;
		due_tokens.push_back(t);
	endfunction

	function automatic void flush_pending();
		if (lx_mode == tsc_pkg::MODE_NUMBER) begin
			emit(tsc_pkg::KIND_NUMBER, lx_value, lx_start, lx_length);
		end else if (lx_mode == tsc_pkg::MODE_IDENT) begin
			emit(tsc_pkg::KIND_IDENT, 31'd0, lx_start, lx_length);
		end
		lx_mode = tsc_pkg::MODE_IDLE;
		lx_value = '0;
		lx_start = '0;
		lx_length = '0;
	endfunction

	function automatic void lex_byte(input logic [7:0] ch, input logic eot);
		int first;
		logic [63:0] nv;
		tsc_pkg::kind_t sym;
		tsc_pkg::tok_t t;
		first = due_tokens.size();
		if (lx_mode == tsc_pkg::MODE_NUMBER && is_digit(ch)) begin
			nv = lx_value * 64'd10 + (ch - 8'h30);
			lx_value = (nv > tsc_pkg::VALUE_MAX) ? tsc_pkg::VALUE_MAX : nv[30:0];
			if (lx_length < tsc_pkg::LENGTH_MAX) lx_length++;
		end else if (lx_mode == tsc_pkg::MODE_IDENT && (is_digit(ch) || is_alpha(ch))) begin
			if (lx_length < tsc_pkg::LENGTH_MAX) lx_length++;
		end else begin
			flush_pending();
			if (is_digit(ch)) begin
				lx_mode = tsc_pkg::MODE_NUMBER;
				lx_value = 31'(ch - 8'h30);
				lx_start = lx_pos;
				lx_length = 16'd1;
			end else if (is_alpha(ch)) begin
				lx_mode = tsc_pkg::MODE_IDENT;
				lx_value = '0;
				lx_start = lx_pos;
				lx_length = 16'd1;
			end else if (!is_space(ch)) begin
				case (ch)
					"+": sym = tsc_pkg::KIND_PLUS;
					"-": sym = tsc_pkg::KIND_MINUS;
					"*": sym = tsc_pkg::KIND_TIMES;
					"/": sym = tsc_pkg::KIND_DIVIDE;
					"=": sym = tsc_pkg::KIND_EQUALS;
					"!": sym = tsc_pkg::KIND_NOT;
					"&": sym = tsc_pkg::KIND_AND;
					";": sym = tsc_pkg::KIND_SEMI;
					default: sym = tsc_pkg::KIND_UNKNOWN;
				endcase
				emit(sym, 31'd0, lx_pos, 16'd1);
			end
		end
		lx_pos++;
		if (eot) begin
			flush_pending();
			emit(tsc_pkg::KIND_END, 31'd0, lx_pos, 16'd0);
			lx_pos = '0;
		end
		if (due_tokens.size() > first) begin
			t = due_tokens.pop_back();
			t.last = 1'b1;
			due_tokens.push_back(t);
		end
	endfunction

	task automatic put_byte(input logic [7:0] ch, input logic eot, input bit steady);
		int gap;
		if (!steady && burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				text_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		if (burst_left > 0) burst_left--;
		@(negedge clk);
		text_valid <= 1'b1;
		text_byte <= ch;
		end_of_text <= eot;
		do @(posedge clk); while (!text_ready);
		lex_byte(ch, eot);
		bytes_sent++;
		if (eot) texts_ended++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		text_valid <= 1'b0;
		while (due_tokens.size() != 0) @(posedge clk);
	endtask

	task automatic random_piece(inout int counted);
		logic [7:0] word [$];
		int pick;
		int n;
		logic eot;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
			repeat (n) word.push_back(8'(8'h30 + $urandom_range(0, 9)));
		end else if (pick < 55) begin
			word.push_back(rand_letter());
			repeat ($urandom_range(0, 6))
				word.push_back(($urandom_range(0, 2) == 0) ?
					8'(8'h30 + $urandom_range(0, 9)) : rand_letter());
		end else if (pick < 70) begin
			word.push_back(symbols[$urandom_range(0, 7)]);
		end else if (pick < 85) begin
			repeat ($urandom_range(1, 2)) begin
				n = $urandom_range(8, 13);
				word.push_back((n == 8) ? 8'h20 : 8'(n));
			end
		end else if (pick < 95) begin
			word.push_back(8'($urandom_range(0, 255)));
		end else begin
			word.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8))
				: 8'($urandom_range(128, 255)));
		end
		foreach (word[i]) begin
			eot = (i == word.size() - 1) && ($urandom_range(0, 11) == 0);
			put_byte(word[i], eot, 1'b0);
			if (!is_space(word[i]) || eot) counted++;
		end
	endtask

	function automatic void check_field(input string name, input longint exp_v,
			input longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			faults++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && token_valid && token_ready) begin
			if (due_tokens.size() == 0) begin
				$display("%0t: unexpected token, expected none, got kind %0d start %0d",
					$time, token_kind, token_start);
				faults++;
			end else begin
				want = due_tokens.pop_front();
				check_field("token_kind", want.kind, token_kind);
				check_field("number_value", want.value, number_value);
				check_field("token_start", want.start, token_start);
				check_field("token_length", want.length, token_length);
				check_field("last_of_run", want.last, last_of_run);
				tokens_checked++;
			end
		end
	end

	initial begin
		int cyc;
		int stall_pct;
		cyc = 0;
		stall_pct = 0;
		token_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (cyc % 64 == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			token_ready <= ($urandom_range(0, 99) >= stall_pct);
			cyc++;
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((text_valid && text_ready) || (token_valid && token_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("tb failed");
		$finish;
	end

	initial begin
		tsc_pkg::tok_t fixed;
		int random_items;
		bit pressed;
		random_items = 0;
		pressed = 1'b0;
		arst_n = 1'b0;
		text_valid = 1'b0;
		text_byte = 8'h00;
		end_of_text = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			put_byte(plan[i].ch, plan[i].eot, 1'b0);
			if (plan[i].typed) begin
				void'(due_tokens.pop_back());
				fixed.kind = plan[i].kind;
				fixed.value = '0;
				fixed.start = plan[i].start;
				fixed.length = plan[i].len;
				fixed.last = 1'b1;
				due_tokens.push_back(fixed);
			end
		end
		wait_drained();

		// identifier cut by a symbol, then a final byte that gives three tokens
		put_byte(rand_letter(), 1'b0, 1'b1);
		repeat (IDENT_LEN - 1)
			put_byte(($urandom_range(0, 3) == 0) ? 8'(8'h30 + $urandom_range(0, 9))
				: rand_letter(), 1'b0, 1'b1);
		put_byte("+", 1'b0, 1'b1);
		put_byte("7", 1'b0, 1'b1);
		put_byte(";", 1'b1, 1'b1);

		while (random_items < RANDOM_ITEMS) begin
			random_piece(random_items);
			if (!pressed && random_items >= RANDOM_ITEMS / 2) begin
				wait_drained();
				pressed = 1'b1;
			end
		end
		wait_drained();
		repeat (8) @(posedge clk);

		$display("Sent %0d bytes over %0d texts in bursts and gaps, receiver stalling;",
			bytes_sent, texts_ended);
		$display("compared %0d tokens against the scanner model, %0d mismatches.",
			tokens_checked, faults);
		if (faults == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
